@@ design/iof_pkg.sv @@
package iof_pkg;

    localparam int QUAT_WIDTH = 32;
    localparam int FRAC       = QUAT_WIDTH - 2;
    localparam int WIDE       = 64;
    localparam int CNT_W      = 7;

    localparam logic [15:0] BETA_RESET   = 16'd6554;
    localparam logic [31:0] THRESH_RESET = 32'd125829;

    localparam logic REG_BETA   = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } state_t;

    // Handshake between the sequencer and the shared serial multiplier.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } mul_ctl_t;

    function automatic logic [WIDE-1:0] mag(input logic signed [WIDE-1:0] a);
        mag = a[WIDE-1] ? WIDE'(-a) : a;
    endfunction

endpackage

@@ design/iof_serial_mul.sv @@
module iof_serial_mul
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [iof_pkg::WIDE-1:0] op_a,
    input  logic signed [iof_pkg::WIDE-1:0] op_b,
    input  logic [5:0]                    shift,
    output iof_pkg::mul_ctl_t             ctl,
    output logic signed [iof_pkg::WIDE-1:0] product
);

    // Shift-and-add multiplier: one multiplier bit per cycle on magnitudes,
    // then round half away from zero and restore the sign.
    logic [iof_pkg::WIDE-1:0]   mc_reg, mc_next;
    logic [iof_pkg::WIDE-1:0]   mp_reg, mp_next;
    logic [2*iof_pkg::WIDE-1:0] acc_reg, acc_next;
    logic [5:0]                 sh_reg, sh_next;
    logic                       neg_reg, neg_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [6:0]                 cnt_reg, cnt_next;
    logic [2*iof_pkg::WIDE-1:0] rnd;
    logic [iof_pkg::WIDE-1:0]   res;

    always_comb
    begin
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            mc_next   = iof_pkg::mag(op_a);
            mp_next   = iof_pkg::mag(op_b);
            acc_next  = '0;
            sh_next   = shift;
            neg_next  = op_a[iof_pkg::WIDE-1] ^ op_b[iof_pkg::WIDE-1];
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            if (mp_reg[0])
            begin
                acc_next = acc_reg + ((2*iof_pkg::WIDE)'(mc_reg) << cnt_reg[5:0]);
            end
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'(iof_pkg::WIDE-1) || mp_next == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (sh_reg == 6'd0)
        begin
            rnd = acc_reg;
        end
        else
        begin
            rnd = (acc_reg + ((2*iof_pkg::WIDE)'(1) << (sh_reg - 6'd1))) >> sh_reg;
        end
        if (rnd > (2*iof_pkg::WIDE)'(64'h4000_0000_0000_0000))
        begin
            res = 64'h4000_0000_0000_0000;
        end
        else
        begin
            res = rnd[iof_pkg::WIDE-1:0];
        end
        product = neg_reg ? -$signed(res) : $signed(res);
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        neg_reg <= neg_next;
    end

endmodule

@@ design/iof_norm4.sv @@
module iof_norm4
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [iof_pkg::WIDE-1:0] v0,
    input  logic signed [iof_pkg::WIDE-1:0] v1,
    input  logic signed [iof_pkg::WIDE-1:0] v2,
    input  logic signed [iof_pkg::WIDE-1:0] v3,
    output logic                            done,
    output logic signed [iof_pkg::WIDE-1:0] o0,
    output logic signed [iof_pkg::WIDE-1:0] o1,
    output logic signed [iof_pkg::WIDE-1:0] o2,
    output logic signed [iof_pkg::WIDE-1:0] o3
);

    // Normalizes a four-vector. Scale search one bit a cycle, squares by a
    // bit-serial square-accumulate, root two bits a cycle, then each
    // component by restoring division one quotient bit a cycle.
    typedef enum logic [2:0] {
        N_IDLE, N_SCALE, N_SQ, N_ROOT, N_DIV, N_DONE
    } nstate_t;

    localparam int W = iof_pkg::WIDE;

    nstate_t         st_reg, st_next;
    logic [W-1:0]    u_reg [4];
    logic [W-1:0]    u_next [4];
    logic [3:0]      sgn_reg, sgn_next;
    logic [W-1:0]    m_reg, m_next;
    logic [W-1:0]    sum_reg, sum_next;
    logic [W-1:0]    x_reg, x_next;
    logic [W-1:0]    r_reg, r_next;
    logic [W-1:0]    bit_reg, bit_next;
    logic [W-1:0]    rem_reg, rem_next;
    logic [W-1:0]    q_reg, q_next;
    logic [1:0]      idx_reg, idx_next;
    logic [5:0]      k_reg, k_next;
    logic [W-1:0]    sq_mp_reg, sq_mp_next;
    logic signed [W-1:0] out_reg [4];
    logic signed [W-1:0] out_next [4];
    logic [W-1:0]    rem2;

    always_comb
    begin
        st_next    = st_reg;
        sgn_next   = sgn_reg;
        m_next     = m_reg;
        sum_next   = sum_reg;
        x_next     = x_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        sq_mp_next = sq_mp_reg;
        rem2       = '0;
        for (int i = 0; i < 4; i++)
        begin
            u_next[i]   = u_reg[i];
            out_next[i] = out_reg[i];
        end
        case (st_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    u_next[0] = iof_pkg::mag(v0);
                    u_next[1] = iof_pkg::mag(v1);
                    u_next[2] = iof_pkg::mag(v2);
                    u_next[3] = iof_pkg::mag(v3);
                    sgn_next  = {v3[W-1], v2[W-1], v1[W-1], v0[W-1]};
                    m_next    = '0;
                    idx_next  = '0;
                    k_next    = '0;
                    st_next   = N_SCALE;
                end
            end
            N_SCALE:
            begin
                // First cycle finds the maximum over the four magnitudes.
                if (k_reg == 6'd0)
                begin
                    m_next = u_reg[0];
                    for (int i = 1; i < 4; i++)
                    begin
                        if (u_reg[i] > m_next)
                        begin
                            m_next = u_reg[i];
                        end
                    end
                    k_next = 6'd1;
                    if (m_next == '0)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            out_next[i] = '0;
                        end
                        st_next = N_DONE;
                    end
                end
                else if (m_reg >= (W'(1) << 31))
                begin
                    m_next = m_reg >> 1;
                    for (int i = 0; i < 4; i++)
                    begin
                        u_next[i] = u_reg[i] >> 1;
                    end
                end
                else if (m_reg < (W'(1) << 30))
                begin
                    m_next = m_reg << 1;
                    for (int i = 0; i < 4; i++)
                    begin
                        u_next[i] = u_reg[i] << 1;
                    end
                end
                else
                begin
                    sum_next   = '0;
                    idx_next   = '0;
                    k_next     = '0;
                    sq_mp_next = u_reg[0];
                    st_next    = N_SQ;
                end
            end
            N_SQ:
            begin
                if (sq_mp_reg[0])
                begin
                    sum_next = sum_reg + (u_reg[idx_reg] << k_reg);
                end
                sq_mp_next = sq_mp_reg >> 1;
                k_next     = k_reg + 6'd1;
                if (k_reg == 6'd31)
                begin
                    k_next = '0;
                    if (idx_reg == 2'd3)
                    begin
                        x_next   = sum_next;
                        r_next   = '0;
                        bit_next = W'(1) << 62;
                        st_next  = N_ROOT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        sq_mp_next = u_reg[idx_reg + 2'd1];
                    end
                end
            end
            N_ROOT:
            begin
                if (bit_reg == '0)
                begin
                    idx_next = '0;
                    k_next   = '0;
                    if (u_reg[0] >= r_reg)
                    begin
                        rem_next = u_reg[0] - r_reg;
                        q_next   = W'(1);
                    end
                    else
                    begin
                        rem_next = u_reg[0];
                        q_next   = '0;
                    end
                    st_next = N_DIV;
                end
                else
                begin
                    if (bit_reg > x_reg && r_reg == '0)
                    begin
                        bit_next = bit_reg >> 2;
                    end
                    else
                    begin
                        if (x_reg >= r_reg + bit_reg)
                        begin
                            x_next = x_reg - (r_reg + bit_reg);
                            r_next = (r_reg >> 1) + bit_reg;
                        end
                        else
                        begin
                            r_next = r_reg >> 1;
                        end
                        bit_next = bit_reg >> 2;
                    end
                end
            end
            N_DIV:
            begin
                rem2 = rem_reg << 1;
                if (k_reg == 6'(iof_pkg::FRAC))
                begin
                    out_next[idx_reg] = sgn_reg[idx_reg]
                        ? -$signed(q_reg + W'(rem2 >= r_reg))
                        : $signed(q_reg + W'(rem2 >= r_reg));
                    k_next = '0;
                    if (idx_reg == 2'd3)
                    begin
                        st_next = N_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                        if (u_reg[idx_reg + 2'd1] >= r_reg)
                        begin
                            rem_next = u_reg[idx_reg + 2'd1] - r_reg;
                            q_next   = W'(1);
                        end
                        else
                        begin
                            rem_next = u_reg[idx_reg + 2'd1];
                            q_next   = '0;
                        end
                    end
                end
                else
                begin
                    if (rem2 >= r_reg)
                    begin
                        rem_next = rem2 - r_reg;
                        q_next   = (q_reg << 1) | W'(1);
                    end
                    else
                    begin
                        rem_next = rem2;
                        q_next   = q_reg << 1;
                    end
                    k_next = k_reg + 6'd1;
                end
            end
            N_DONE:
            begin
                st_next = N_IDLE;
            end
            default:
            begin
                st_next = N_IDLE;
            end
        endcase
    end

    assign done = (st_reg == N_DONE);
    assign o0   = out_reg[0];
    assign o1   = out_reg[1];
    assign o2   = out_reg[2];
    assign o3   = out_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= N_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sgn_reg   <= sgn_next;
        m_reg     <= m_next;
        sum_reg   <= sum_next;
        x_reg     <= x_next;
        r_reg     <= r_next;
        bit_reg   <= bit_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        idx_reg   <= idx_next;
        k_reg     <= k_next;
        sq_mp_reg <= sq_mp_next;
        for (int i = 0; i < 4; i++)
        begin
            u_reg[i]   <= u_next[i];
            out_reg[i] <= out_next[i];
        end
    end

endmodule

@@ design/imu_orientation_filter_step.sv @@
// IMU orientation filter step.
// Input channel: in_valid / in_stall carry one transaction of accelerometer,
// gyroscope and time step fields. Output channel: out_valid / out_stall carry
// the orientation quaternion (Q2.30) after that step and an updated flag.
// Exactly one result transaction follows each input transaction.
// Configuration: cfg_we, cfg_index, cfg_data write beta_gain (index 0) or
// gyro_still_threshold (index 1). Write only while the block is idle.
// Flow: a gated sample (still gyro or zero acceleration) skips the update;
// the state moves to the output state and the result is then offered from
// the output valid register. An update runs 36 products through one
// bit-serial multiplier (finishing early when the multiplier operand is
// short) and three normalizations (scale search, serial squares, root two
// bits a cycle, then a quotient for each component by restoring division).
// One sample is processed at a time.
// Reset puts the orientation at identity and the registers at their
// defaults. When the receiver stalls, the result is held and no new input
// transaction is accepted until it is taken.
module imu_orientation_filter_step
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic signed [15:0] gyro_z,
    input  logic        [15:0] delta_t,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] orient_w,
    output logic signed [31:0] orient_x,
    output logic signed [31:0] orient_y,
    output logic signed [31:0] orient_z,
    output logic               updated,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic        [31:0] cfg_data
);

    localparam int W  = iof_pkg::WIDE;
    localparam int QW = iof_pkg::QUAT_WIDTH;
    localparam int F  = iof_pkg::FRAC;

    // Work register file: 0..3 q, 4..6 gyro, 7 dt, 8 beta, 9..12 rate,
    // 13..15 accel, 16..18 f, 19..22 grad / gh, 23..26 qn.
    localparam int NR = 27;

    // Microprogram step: operation kind, destination, sources, shift.
    typedef enum logic [1:0] {
        OP_SET, OP_ADD, OP_SUB, OP_NSET
    } acc_op_t;

    iof_pkg::state_t st_reg, st_next;

    logic [15:0] beta_reg;
    logic [31:0] thresh_reg;
    logic signed [QW-1:0] q_reg [4];
    logic signed [W-1:0]  wr_reg [NR];
    logic        upd_reg;
    logic        out_valid_reg;
    logic [5:0]  pc_reg, pc_next;
    logic [1:0]  nphase_reg, nphase_next;

    logic        mul_start;
    logic signed [W-1:0] mul_a, mul_b, mul_p;
    logic [5:0]  mul_sh;
    iof_pkg::mul_ctl_t mul_ctl;
    logic        norm_start, norm_done;
    logic signed [W-1:0] nv [4];
    logic signed [W-1:0] no [4];

    logic [4:0]  s_a, s_b, s_d;
    logic [5:0]  s_sh;
    acc_op_t     s_op;
    logic        s_c;
    logic signed [W-1:0] konst;

    logic signed [31:0] gx_ext, gy_ext, gz_ext;
    logic [31:0] gsq;
    logic        gate;
    logic        accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (st_reg != iof_pkg::ST_IDLE) || out_valid_reg;

    always_comb
    begin
        gx_ext = 32'(gyro_x);
        gy_ext = 32'(gyro_y);
        gz_ext = 32'(gyro_z);
        gsq = gx_ext * gx_ext + gy_ext * gy_ext + gz_ext * gz_ext;
        gate = (gsq < thresh_reg) || (accel_x == 16'sd0 && accel_y == 16'sd0
            && accel_z == 16'sd0);
    end

    // Product program: dst op= round(src_a*src_b >> sh). s_c adds a
    // constant "one" into the destination before the product (for f2).
    always_comb
    begin
        s_a = 5'd0; s_b = 5'd0; s_d = 5'd0; s_sh = 6'd0; s_op = OP_SET; s_c = 1'b0;
        case (pc_reg)
            6'd0:  begin s_d=9;  s_a=1; s_b=4; s_sh=13; s_op=OP_NSET; end
            6'd1:  begin s_d=9;  s_a=2; s_b=5; s_sh=13; s_op=OP_SUB; end
            6'd2:  begin s_d=9;  s_a=3; s_b=6; s_sh=13; s_op=OP_SUB; end
            6'd3:  begin s_d=10; s_a=0; s_b=4; s_sh=13; s_op=OP_SET; end
            6'd4:  begin s_d=10; s_a=2; s_b=6; s_sh=13; s_op=OP_ADD; end
            6'd5:  begin s_d=10; s_a=3; s_b=5; s_sh=13; s_op=OP_SUB; end
            6'd6:  begin s_d=11; s_a=0; s_b=5; s_sh=13; s_op=OP_SET; end
            6'd7:  begin s_d=11; s_a=1; s_b=6; s_sh=13; s_op=OP_SUB; end
            6'd8:  begin s_d=11; s_a=3; s_b=4; s_sh=13; s_op=OP_ADD; end
            6'd9:  begin s_d=12; s_a=0; s_b=6; s_sh=13; s_op=OP_SET; end
            6'd10: begin s_d=12; s_a=1; s_b=5; s_sh=13; s_op=OP_ADD; end
            6'd11: begin s_d=12; s_a=2; s_b=4; s_sh=13; s_op=OP_SUB; end
            6'd12: begin s_d=16; s_a=1; s_b=3; s_sh=6'(F-1); s_op=OP_ADD; end
            6'd13: begin s_d=16; s_a=0; s_b=2; s_sh=6'(F-1); s_op=OP_SUB; end
            6'd14: begin s_d=17; s_a=0; s_b=1; s_sh=6'(F-1); s_op=OP_ADD; end
            6'd15: begin s_d=17; s_a=2; s_b=3; s_sh=6'(F-1); s_op=OP_ADD; end
            6'd16: begin s_d=18; s_a=1; s_b=1; s_sh=6'(F-1); s_op=OP_SUB; s_c=1'b1; end
            6'd17: begin s_d=18; s_a=2; s_b=2; s_sh=6'(F-1); s_op=OP_SUB; end
            6'd18: begin s_d=19; s_a=2; s_b=16; s_sh=6'(F-1); s_op=OP_NSET; end
            6'd19: begin s_d=19; s_a=1; s_b=17; s_sh=6'(F-1); s_op=OP_ADD; end
            6'd20: begin s_d=20; s_a=3; s_b=16; s_sh=6'(F-1); s_op=OP_SET; end
            6'd21: begin s_d=20; s_a=0; s_b=17; s_sh=6'(F-1); s_op=OP_ADD; end
            6'd22: begin s_d=20; s_a=1; s_b=18; s_sh=6'(F-2); s_op=OP_SUB; end
            6'd23: begin s_d=21; s_a=0; s_b=16; s_sh=6'(F-1); s_op=OP_NSET; end
            6'd24: begin s_d=21; s_a=3; s_b=17; s_sh=6'(F-1); s_op=OP_ADD; end
            6'd25: begin s_d=21; s_a=2; s_b=18; s_sh=6'(F-2); s_op=OP_SUB; end
            6'd26: begin s_d=22; s_a=1; s_b=16; s_sh=6'(F-1); s_op=OP_SET; end
            6'd27: begin s_d=22; s_a=2; s_b=17; s_sh=6'(F-1); s_op=OP_ADD; end
            6'd28: begin s_d=19; s_a=19; s_b=8; s_sh=16; s_op=OP_SET; end
            6'd29: begin s_d=20; s_a=20; s_b=8; s_sh=16; s_op=OP_SET; end
            6'd30: begin s_d=21; s_a=21; s_b=8; s_sh=16; s_op=OP_SET; end
            6'd31: begin s_d=22; s_a=22; s_b=8; s_sh=16; s_op=OP_SET; end
            6'd32: begin s_d=23; s_a=9;  s_b=7; s_sh=16; s_op=OP_SET; end
            6'd33: begin s_d=24; s_a=10; s_b=7; s_sh=16; s_op=OP_SET; end
            6'd34: begin s_d=25; s_a=11; s_b=7; s_sh=16; s_op=OP_SET; end
            6'd35: begin s_d=26; s_a=12; s_b=7; s_sh=16; s_op=OP_SET; end
            default: begin s_d=0; s_op=OP_SET; end
        endcase
    end

    // The rates stay in 9..12 until the integration steps read them.
    assign konst = s_c ? (W'(1) << F) : '0;

    assign mul_a = wr_reg[s_a];
    assign mul_b = wr_reg[s_b];
    assign mul_sh = s_sh;

    iof_serial_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .shift   (mul_sh),
        .ctl     (mul_ctl),
        .product (mul_p)
    );

    // Normalizer inputs by phase: accel, gradient, integrated quaternion.
    always_comb
    begin
        case (nphase_reg)
            2'd0:
            begin
                nv[0] = '0;
                nv[1] = wr_reg[13];
                nv[2] = wr_reg[14];
                nv[3] = wr_reg[15];
            end
            2'd1:
            begin
                nv[0] = wr_reg[19];
                nv[1] = wr_reg[20];
                nv[2] = wr_reg[21];
                nv[3] = wr_reg[22];
            end
            default:
            begin
                nv[0] = wr_reg[23];
                nv[1] = wr_reg[24];
                nv[2] = wr_reg[25];
                nv[3] = wr_reg[26];
            end
        endcase
    end

    iof_norm4 u_norm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .v0    (nv[0]),
        .v1    (nv[1]),
        .v2    (nv[2]),
        .v3    (nv[3]),
        .done  (norm_done),
        .o0    (no[0]),
        .o1    (no[1]),
        .o2    (no[2]),
        .o3    (no[3])
    );

    // Sequence: normalize accel, products 0..27, normalize gradient,
    // products 28..35, add q, normalize qn.
    always_comb
    begin
        st_next     = st_reg;
        pc_next     = pc_reg;
        nphase_next = nphase_reg;
        case (st_reg)
            iof_pkg::ST_IDLE:
            begin
                if (accept && !gate)
                begin
                    st_next     = iof_pkg::ST_SQRT;
                    nphase_next = 2'd0;
                    pc_next     = '0;
                end
                else if (accept)
                begin
                    st_next = iof_pkg::ST_OUT;
                end
            end
            iof_pkg::ST_SQRT:
            begin
                if (norm_done)
                begin
                    st_next = iof_pkg::ST_MUL;
                end
            end
            iof_pkg::ST_MUL:
            begin
                if (mul_ctl.done)
                begin
                    pc_next = pc_reg + 6'd1;
                    if (pc_reg == 6'd27)
                    begin
                        nphase_next = 2'd1;
                        st_next     = iof_pkg::ST_SQRT;
                    end
                    else if (pc_reg == 6'd35)
                    begin
                        nphase_next = 2'd2;
                        st_next     = iof_pkg::ST_DIV;
                    end
                end
            end
            iof_pkg::ST_DIV:
            begin
                if (norm_done)
                begin
                    st_next = iof_pkg::ST_OUT;
                end
            end
            iof_pkg::ST_OUT:
            begin
                st_next = iof_pkg::ST_IDLE;
            end
            default:
            begin
                st_next = iof_pkg::ST_IDLE;
            end
        endcase
    end

    // Kick the multiplier when a step is entered and the unit is free;
    // kick the normalizer on entry to a normalize state.
    logic kick_reg;
    logic prev_norm_reg;

    always_comb
    begin
        mul_start  = (st_reg == iof_pkg::ST_MUL) && !mul_ctl.busy && !mul_ctl.done
            && !kick_reg;
        norm_start = ((st_reg == iof_pkg::ST_SQRT) || (st_reg == iof_pkg::ST_DIV))
            && !prev_norm_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= iof_pkg::ST_IDLE;
            pc_reg        <= '0;
            nphase_reg    <= '0;
            beta_reg      <= iof_pkg::BETA_RESET;
            thresh_reg    <= iof_pkg::THRESH_RESET;
            q_reg[0]      <= QW'(1) << F;
            q_reg[1]      <= '0;
            q_reg[2]      <= '0;
            q_reg[3]      <= '0;
            out_valid_reg <= 1'b0;
            upd_reg       <= 1'b0;
            kick_reg      <= 1'b0;
            prev_norm_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            pc_reg     <= pc_next;
            nphase_reg <= nphase_next;
            kick_reg   <= mul_start;
            prev_norm_reg <= (norm_start || prev_norm_reg) && !norm_done;
            if (cfg_we)
            begin
                if (cfg_index == iof_pkg::REG_BETA)
                begin
                    beta_reg <= cfg_data[15:0];
                end
                else
                begin
                    thresh_reg <= cfg_data;
                end
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (st_reg == iof_pkg::ST_IDLE && accept)
            begin
                upd_reg <= !gate;
            end
            if (st_reg == iof_pkg::ST_DIV && norm_done)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    q_reg[i] <= QW'(no[i]);
                end
            end
            if (st_reg == iof_pkg::ST_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == iof_pkg::ST_IDLE && accept)
        begin
            for (int i = 0; i < 4; i++)
            begin
                wr_reg[i] <= W'(q_reg[i]);
            end
            wr_reg[4]  <= W'(gyro_x);
            wr_reg[5]  <= W'(gyro_y);
            wr_reg[6]  <= W'(gyro_z);
            wr_reg[7]  <= W'({1'b0, delta_t});
            wr_reg[8]  <= W'({1'b0, beta_reg});
            wr_reg[13] <= W'(accel_x);
            wr_reg[14] <= W'(accel_y);
            wr_reg[15] <= W'(accel_z);
        end
        if (st_reg == iof_pkg::ST_SQRT && norm_done && nphase_reg == 2'd0)
        begin
            // The accel unit vector seeds the f terms: they start at -a.
            wr_reg[16] <= -no[1];
            wr_reg[17] <= -no[2];
            wr_reg[18] <= -no[3];
        end
        if (st_reg == iof_pkg::ST_SQRT && norm_done && nphase_reg == 2'd1)
        begin
            wr_reg[19] <= no[0];
            wr_reg[20] <= no[1];
            wr_reg[21] <= no[2];
            wr_reg[22] <= no[3];
        end
        if (st_reg == iof_pkg::ST_MUL && mul_ctl.done)
        begin
            if (pc_reg >= 6'd32)
            begin
                // Integration: qn = q + round((rate - beta*gh) * dt).
                wr_reg[s_d] <= wr_reg[5'(pc_reg - 6'd32)] + mul_p;
            end
            else
            begin
                case (s_op)
                    OP_SET:  wr_reg[s_d] <= mul_p;
                    OP_ADD:  wr_reg[s_d] <= wr_reg[s_d] + konst + mul_p;
                    OP_SUB:  wr_reg[s_d] <= wr_reg[s_d] + konst - mul_p;
                    OP_NSET: wr_reg[s_d] <= -mul_p;
                    default: wr_reg[s_d] <= mul_p;
                endcase
                // Each rate picks up -beta*gh.
                if (pc_reg >= 6'd28)
                begin
                    wr_reg[5'(pc_reg - 6'd19)] <= wr_reg[5'(pc_reg - 6'd19)] - mul_p;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign orient_w  = q_reg[0];
    assign orient_x  = q_reg[1];
    assign orient_y  = q_reg[2];
    assign orient_z  = q_reg[3];
    assign updated   = upd_reg;

endmodule
